// ----- sv/mpc_pkg.sv -----
// Package for the masked Pearson correlation block.
// Controller states, datapath step codes, command and status structs.
// No dependencies.
package mpc_pkg;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_START,
    ST_RUN,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    STEP_NSXX,
    STEP_UXX,
    STEP_NSYY,
    STEP_UYY,
    STEP_NSXY,
    STEP_SXSY,
    STEP_P,
    STEP_Q,
    STEP_S2,
    STEP_TRY
  } step_t;

  localparam int CFG_IDX_BITS = 2;
  localparam int PED_BITS     = 12;
  localparam int COEF_BITS    = 16;
  localparam int K_BITS       = 16;
  localparam int BIT_IDX_BITS = 4;
  localparam int Q_SHIFT      = 32;

  localparam logic [CFG_IDX_BITS-1:0] REG_PED_A = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PED_B = 2'd1;

  localparam logic [5:0]           LOW_MASK = 6'h3F;
  localparam logic [K_BITS-1:0]    K_MAX    = 16'd32768;
  localparam logic [K_BITS-1:0]    COEF_POS_MAX = 16'd32767;
  localparam logic [BIT_IDX_BITS-1:0] BIT_TOP = 4'd15;

  typedef struct packed {
    logic                    accept;
    logic                    start;
    step_t                   step;
    logic [BIT_IDX_BITS-1:0] bit_idx;
    logic                    load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic calc_ok;
    logic out_free;
  } status_t;

endpackage

// ----- sv/mpc_mul.sv -----
// Shift-add multiplier, one bit of b per cycle.
// Used by mpc_datapath for all wide products; no package dependency.
module mpc_mul #(
  parameter int AW = 144,
  parameter int BW = 55
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [AW-1:0] product,
  output logic          done
);

  localparam int CNTW = $clog2(BW + 1);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [AW-1:0]   acc;
  logic [AW-1:0]   ash;
  logic [BW-1:0]   bsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(BW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      ash <= a;
      bsh <= b;
    end else if (busy) begin
      if (bsh[0]) acc <= acc + ash;
      ash <= {ash[AW-2:0], 1'b0};
      bsh <= {1'b0, bsh[BW-1:1]};
    end
  end

  assign product = acc;

endmodule

// ----- sv/mpc_datapath.sv -----
// Datapath: pedestal registers, running sums, end-of-record arithmetic, output register.
// Depends on mpc_pkg and mpc_mul.
module mpc_datapath #(
  parameter int MAX_TICKS   = 16384,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mpc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [mpc_pkg::PED_BITS-1:0]        cfg_data,
  input  logic [SAMPLE_BITS-1:0]              raw_sample_a,
  input  logic [SAMPLE_BITS-1:0]              raw_sample_b,
  input  mpc_pkg::cmd_t                       cmd,
  output mpc_pkg::status_t                    status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mpc_pkg::COEF_BITS-1:0] coefficient,
  output logic                                coefficient_valid
);
  import mpc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_TICKS + 1);
  localparam int XW   = SB + 1;
  localparam int SW   = SB + CW + 1;
  localparam int XYW  = 2 * SB + CW + 1;
  localparam int XXW  = 2 * SB + CW;
  localparam int VW   = 2 * SB + 2 * CW;
  localparam int CUW  = VW + 2;
  localparam int BW   = (VW + 1 > 2 * (K_BITS + 1)) ? VW + 1 : 2 * (K_BITS + 1);
  localparam int PW   = 2 * VW + Q_SHIFT + 4;
  localparam int PADW = (SB > PED_BITS) ? SB : PED_BITS;
  localparam int S_W  = K_BITS + 1;
  localparam int S2W  = 2 * S_W;

  logic [PED_BITS-1:0] ped_a;
  logic [PED_BITS-1:0] ped_b;

  logic [CW-1:0]         pair_count;
  logic signed [SW-1:0]  sum_x;
  logic signed [SW-1:0]  sum_y;
  logic signed [XYW-1:0] sum_xy;
  logic [XXW-1:0]        sum_xx;
  logic [XXW-1:0]        sum_yy;

  // sample conditioning
  logic [PADW-1:0]        ped_a_w, ped_b_w;
  logic signed [XW-1:0]   x, y;
  logic signed [2*XW-1:0] xy, xx, yy;
  logic                   mask_x, mask_y;

  assign ped_a_w = PADW'(ped_a);
  assign ped_b_w = PADW'(ped_b);
  assign x = $signed({1'b0, raw_sample_a}) - $signed({1'b0, ped_a_w[SB-1:0]});
  assign y = $signed({1'b0, raw_sample_b}) - $signed({1'b0, ped_b_w[SB-1:0]});
  assign xy = x * y;
  assign xx = x * x;
  assign yy = y * y;
  assign mask_x = (x[5:0] == '0) || (x[5:0] == LOW_MASK);
  assign mask_y = (y[5:0] == '0) || (y[5:0] == LOW_MASK);

  always_ff @(posedge clk) begin
    if (rst) begin
      ped_a <= '0;
      ped_b <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PED_A: ped_a <= cfg_data;
        REG_PED_B: ped_b <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      pair_count <= '0;
      sum_x      <= '0;
      sum_y      <= '0;
      sum_xy     <= '0;
      sum_xx     <= '0;
      sum_yy     <= '0;
    end else if (cmd.accept && (pair_count < CW'(MAX_TICKS))) begin
      pair_count <= pair_count + 1'b1;
      if (!mask_x && !mask_y) begin
        sum_x  <= sum_x + SW'(x);
        sum_y  <= sum_y + SW'(y);
        sum_xy <= sum_xy + XYW'(xy);
        sum_xx <= sum_xx + XXW'($unsigned(xx));
        sum_yy <= sum_yy + XXW'($unsigned(yy));
      end
    end
  end

  // magnitudes of the signed sums
  logic [SW-1:0]  ux, uy;
  logic [XYW-1:0] uxy;
  assign ux  = sum_x[SW-1]   ? $unsigned(-sum_x)  : $unsigned(sum_x);
  assign uy  = sum_y[SW-1]   ? $unsigned(-sum_y)  : $unsigned(sum_y);
  assign uxy = sum_xy[XYW-1] ? $unsigned(-sum_xy) : $unsigned(sum_xy);

  // end-of-record registers
  logic signed [CUW-1:0] t1;
  logic [VW-1:0]         va, vb;
  logic [VW:0]           cmag;
  logic                  cneg;
  logic                  ok;
  logic [PW-1:0]         pp, qq;
  logic [S2W-1:0]        s2;
  logic [K_BITS-1:0]     k;

  logic [K_BITS-1:0] t;
  logic [S_W-1:0]    s;
  assign t = k | (K_BITS'(1) << cmd.bit_idx);
  assign s = {t, 1'b0} - 1'b1;

  logic [PW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic          mul_done;

  always_comb begin
    case (cmd.step)
      STEP_NSXX: begin mul_a = PW'(sum_xx); mul_b = BW'(pair_count); end
      STEP_UXX:  begin mul_a = PW'(ux);     mul_b = BW'(ux);         end
      STEP_NSYY: begin mul_a = PW'(sum_yy); mul_b = BW'(pair_count); end
      STEP_UYY:  begin mul_a = PW'(uy);     mul_b = BW'(uy);         end
      STEP_NSXY: begin mul_a = PW'(uxy);    mul_b = BW'(pair_count); end
      STEP_SXSY: begin mul_a = PW'(ux);     mul_b = BW'(uy);         end
      STEP_P:    begin mul_a = PW'(va);     mul_b = BW'(vb);         end
      STEP_Q:    begin mul_a = PW'(cmag);   mul_b = BW'(cmag);       end
      STEP_S2:   begin mul_a = PW'(s);      mul_b = BW'(s);          end
      STEP_TRY:  begin mul_a = pp;          mul_b = BW'(s2);         end
      default:   begin mul_a = '0;          mul_b = '0;              end
    endcase
  end

  mpc_mul #(.AW(PW), .BW(BW)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.start),
    .a       (mul_a),
    .b       (mul_b),
    .product (prod),
    .done    (mul_done)
  );

  logic signed [CUW-1:0] prod_s;
  logic signed [CUW-1:0] cu;
  assign prod_s = $signed(prod[CUW-1:0]);
  assign cu = t1 - ((sum_x[SW-1] ^ sum_y[SW-1]) ? -prod_s : prod_s);

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.step)
        STEP_NSXX, STEP_NSYY: t1 <= prod_s;
        STEP_UXX:  va <= t1[VW-1:0] - prod[VW-1:0];
        STEP_UYY:  vb <= t1[VW-1:0] - prod[VW-1:0];
        STEP_NSXY: t1 <= sum_xy[XYW-1] ? -prod_s : prod_s;
        STEP_SXSY: begin
          cneg <= cu[CUW-1];
          cmag <= cu[CUW-1] ? (VW+1)'($unsigned(-cu)) : (VW+1)'($unsigned(cu));
          ok   <= (pair_count != '0) && (va != '0) && (vb != '0);
          k    <= '0;
        end
        STEP_P:    pp <= prod;
        STEP_Q:    qq <= prod << Q_SHIFT;
        STEP_S2:   s2 <= prod[S2W-1:0];
        STEP_TRY:  if ((prod <= qq) && (t <= K_MAX)) k <= t;
        default: ;
      endcase
    end
  end

  // output register
  logic [K_BITS-1:0] coef_mag;
  assign coef_mag = cneg ? (K_BITS'(0) - k) : ((k > COEF_POS_MAX) ? COEF_POS_MAX : k);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      coefficient       <= ok ? $signed(COEF_BITS'(coef_mag)) : '0;
      coefficient_valid <= ok;
    end
  end

  assign status.mul_done = mul_done;
  assign status.calc_ok  = (pair_count != '0) && (va != '0) && (vb != '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

// ----- sv/mpc_ctrl.sv -----
// Controller state machine: input acceptance and the end-of-record step sequence.
// Depends on mpc_pkg.
module mpc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             last_tick,
  output logic             in_ready,
  input  mpc_pkg::status_t status,
  output mpc_pkg::cmd_t    cmd
);
  import mpc_pkg::*;

  state_t                  state, state_next;
  step_t                   step, step_next;
  logic [BIT_IDX_BITS-1:0] bit_idx, bit_idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_ACC;
      step    <= STEP_NSXX;
      bit_idx <= BIT_TOP;
    end else begin
      state   <= state_next;
      step    <= step_next;
      bit_idx <= bit_idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    bit_idx_next = bit_idx;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.start    = 1'b0;
    cmd.step     = step;
    cmd.bit_idx  = bit_idx;
    cmd.load_out = 1'b0;
    case (state)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (last_tick) begin
            state_next = ST_START;
            step_next  = STEP_NSXX;
          end
        end
      end
      ST_START: begin
        cmd.start  = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (status.mul_done) begin
          state_next = ST_START;
          case (step)
            STEP_NSXX: step_next = STEP_UXX;
            STEP_UXX:  step_next = STEP_NSYY;
            STEP_NSYY: step_next = STEP_UYY;
            STEP_UYY:  step_next = STEP_NSXY;
            STEP_NSXY: step_next = STEP_SXSY;
            STEP_SXSY: begin
              if (status.calc_ok) step_next = STEP_P;
              else state_next = ST_FIN;
            end
            STEP_P:    step_next = STEP_Q;
            STEP_Q: begin
              step_next    = STEP_S2;
              bit_idx_next = BIT_TOP;
            end
            STEP_S2:   step_next = STEP_TRY;
            STEP_TRY: begin
              if (bit_idx == '0) begin
                state_next = ST_FIN;
              end else begin
                bit_idx_next = bit_idx - 1'b1;
                step_next    = STEP_S2;
              end
            end
            default:   state_next = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACC;
        end
      end
      default: state_next = ST_ACC;
    endcase
  end

endmodule

// ----- sv/masked_pearson_correlation.sv -----
// Masked Pearson correlation: top level.
// Instantiates mpc_ctrl and mpc_datapath; uses mpc_pkg.
//
// Usage:
//   Sample pairs arrive on the input channel (in_valid / in_ready). Each
//   pair is pedestal-corrected; pairs where either corrected sample has its low six
//   bits all zero or all one are masked out of the sums but still counted.
//   Pairs beyond MAX_TICKS in a record are dropped.
//   Ordinary pairs are taken one per cycle.
//   A pair with last_tick set closes the record: input goes not ready while
//   the coefficient is computed, then one transaction with coefficient
//   (Q1.15, saturated) and coefficient_valid appears on the output channel.
//   The end-of-record work runs through one shift-add multiplier: six
//   products for the moments, two for the squared terms and two per bit of
//   a 16-step bit-by-bit search, the multiplier operand being BW bits wide where
//   BW = max(2*SAMPLE_BITS + 2*clog2(MAX_TICKS+1) + 1, 34), 55 by default.
//   An invalid record (empty or zero variance) stops after the first six.
//   If the receiver stalls, the result register holds and the next record
//   keeps flowing in; its last pair is taken and computed, then the input
//   stays not ready until the held result is taken.
//   Reset (rst, synchronous) clears pedestals, sums, count and output.
//   Pedestal writes on cfg_write take effect at once, with no wait.
module masked_pearson_correlation #(
  parameter int MAX_TICKS   = 16384,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mpc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [mpc_pkg::PED_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [SAMPLE_BITS-1:0]               raw_sample_a,
  input  logic [SAMPLE_BITS-1:0]               raw_sample_b,
  input  logic                                 last_tick,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mpc_pkg::COEF_BITS-1:0] coefficient,
  output logic                                 coefficient_valid
);
  import mpc_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: acceptance, step order, search bit
  mpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .last_tick (last_tick),
    .in_ready  (in_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // sums, multiplier, result register
  mpc_datapath #(
    .MAX_TICKS   (MAX_TICKS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .raw_sample_a      (raw_sample_a),
    .raw_sample_b      (raw_sample_b),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .coefficient       (coefficient),
    .coefficient_valid (coefficient_valid)
  );

endmodule

// ----- bench/masked_pearson_correlation_tb.sv -----
// Self-checking testbench for masked_pearson_correlation.
// Predicts each record's coefficient from pedestal-corrected, masked sums.
// Depends on mpc_pkg and the masked_pearson_correlation RTL.
`timescale 1ns / 100ps

module masked_pearson_correlation_tb;
  import mpc_pkg::*;

  localparam int MAX_TICKS   = 16384;
  localparam int SAMPLE_BITS = 12;
  // allow a record close to finish during drains, with margin
  localparam int CLOSE_WAIT  = 3000;
  localparam int CYCLE_LIMIT = 6000000;

  typedef logic [191:0] wide_t;

  typedef struct {
    logic signed [COEF_BITS-1:0] coef;
    logic                        ok;
  } coef_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [PED_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_BITS-1:0] raw_sample_a = '0;
  logic [SAMPLE_BITS-1:0] raw_sample_b = '0;
  logic last_tick = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COEF_BITS-1:0] coefficient;
  logic coefficient_valid;

  masked_pearson_correlation #(
    .MAX_TICKS(MAX_TICKS),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .raw_sample_a(raw_sample_a), .raw_sample_b(raw_sample_b),
    .last_tick(last_tick),
    .out_valid(out_valid), .out_ready(out_ready),
    .coefficient(coefficient), .coefficient_valid(coefficient_valid)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: shadow pedestals and running record sums
  logic [PED_BITS-1:0] ped_a_model = '0;
  logic [PED_BITS-1:0] ped_b_model = '0;
  longint unsigned pairs_in_record = 0;
  longint sum_x_m = 0, sum_y_m = 0, sum_xy_m = 0;
  longint unsigned sum_xx_m = 0, sum_yy_m = 0;

  coef_result_t pending_coefs[$];
  int err_count = 0;
  int cycle_count = 0;
  bit tx_idle_on = 1'b1;  // sender gaps enabled
  bit rx_idle_on = 1'b1;  // receiver stalls enabled
  logic rx_hold = 1'b0;   // long receiver hold-off (pressure)
  int rx_stall_left = 0;

  function automatic bit low_bits_masked(longint v);
    logic [63:0] bits;
    bits = v;
    return (bits[5:0] == 6'h00) || (bits[5:0] == LOW_MASK);
  endfunction

  // rounded |32768 * c / sqrt(va * vb)|, capped at 32768
  function automatic int unsigned ratio_search(longint unsigned c,
                                               longint unsigned va,
                                               longint unsigned vb);
    wide_t ab, rhs, lhs;
    int unsigned lo, hi, mid;
    longint unsigned odd;
    ab = wide_t'(va) * wide_t'(vb);
    rhs = (wide_t'(c) * wide_t'(c)) << 32;
    lo = 0;
    hi = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      odd = 2 * longint'(mid) - 1;
      lhs = wide_t'(odd * odd) * ab;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  // update sums for one accepted pair; on a last pair produce the coefficient
  task automatic accumulate_pair(input logic [SAMPLE_BITS-1:0] a,
                                 input logic [SAMPLE_BITS-1:0] b,
                                 input logic last);
    longint x, y;
    longint unsigned n, ux, uy, va, vb, cu, cmag;
    int unsigned mag;
    coef_result_t res;
    x = longint'(a) - longint'(ped_a_model);
    y = longint'(b) - longint'(ped_b_model);
    if (pairs_in_record < MAX_TICKS) begin
      pairs_in_record++;
      if (!low_bits_masked(x) && !low_bits_masked(y)) begin
        sum_x_m += x;
        sum_y_m += y;
        sum_xy_m += x * y;
        sum_xx_m += longint'(x * x);
        sum_yy_m += longint'(y * y);
      end
    end
    if (last) begin
      n = pairs_in_record;
      ux = (sum_x_m < 0) ? -sum_x_m : sum_x_m;
      uy = (sum_y_m < 0) ? -sum_y_m : sum_y_m;
      va = n * sum_xx_m - ux * ux;
      vb = n * sum_yy_m - uy * uy;
      res.coef = '0;
      res.ok = 1'b0;
      if (n > 0 && va != 0 && vb != 0) begin
        res.ok = 1'b1;
        cu = n * longint'(sum_xy_m) - longint'(sum_x_m) * longint'(sum_y_m);
        cmag = cu[63] ? -cu : cu;
        mag = ratio_search(cmag, va, vb);
        if (cu[63]) res.coef = COEF_BITS'(-mag);
        else res.coef = COEF_BITS'((mag > COEF_POS_MAX) ? COEF_POS_MAX : mag);
      end
      pending_coefs.insert(pending_coefs.size(), res);
      pairs_in_record = 0;
      sum_x_m = 0; sum_y_m = 0; sum_xy_m = 0; sum_xx_m = 0; sum_yy_m = 0;
    end
  endtask

  // Send one pair; returns right after the accepting edge with valid still
  // high, so back-to-back transactions never toggle valid in one step.
  task automatic send_pair(input logic [SAMPLE_BITS-1:0] a,
                           input logic [SAMPLE_BITS-1:0] b,
                           input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    raw_sample_a <= a;
    raw_sample_b <= b;
    last_tick <= last;
    do @(posedge clk); while (!in_ready);
    accumulate_pair(a, b, last);
  endtask

  // one register write, then idle with the write enable low before returning
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [PED_BITS-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_PED_A) ped_a_model = value;
    else if (idx == REG_PED_B) ped_b_model = value;
  endtask

  // wait until every expected coefficient arrived and the block settled
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (CLOSE_WAIT) @(posedge clk);
  endtask

  task automatic set_pedestals(input logic [PED_BITS-1:0] pa,
                               input logic [PED_BITS-1:0] pb);
    drain();
    write_reg(REG_PED_A, pa);
    write_reg(REG_PED_B, pb);
  endtask

  // random pair: mostly related channels so sums carry real correlation
  task automatic random_pair(output logic [SAMPLE_BITS-1:0] a,
                             output logic [SAMPLE_BITS-1:0] b);
    a = SAMPLE_BITS'($urandom_range(0, 4095));
    case ($urandom_range(0, 3))
      0: b = SAMPLE_BITS'($urandom_range(0, 4095));
      1: b = a + SAMPLE_BITS'($urandom_range(0, 63));
      2: b = ~a + SAMPLE_BITS'($urandom_range(0, 31));
      default: b = a;
    endcase
  endtask

  task automatic test_directed;
    int i;
    set_pedestals(12'd0, 12'd0);
    // extremes, including a masked all-ones raw value
    send_pair(12'd0, 12'd0, 1'b0);
    send_pair(12'hFFF, 12'hFFF, 1'b0);
    send_pair(12'd5, 12'hFFA, 1'b0);
    send_pair(12'd1000, 12'd77, 1'b1);
    // empty sums: lone masked pair gives an invalid result
    send_pair(12'd64, 12'd63, 1'b1);
    // zero variance on one channel
    send_pair(12'd5, 12'd9, 1'b0);
    send_pair(12'd5, 12'd300, 1'b1);
    // perfect positive correlation saturates
    for (i = 1; i <= 5; i++)
      send_pair(SAMPLE_BITS'(i * 7 + 1), SAMPLE_BITS'(i * 7 + 1), i == 5);
    // perfect negative correlation with a pedestal on B
    set_pedestals(12'd0, 12'd2048);
    for (i = 1; i <= 5; i++)
      send_pair(SAMPLE_BITS'(i * 9 + 1), SAMPLE_BITS'(2048 - (i * 9 + 1)), i == 5);
    // writes to unused indexes do nothing
    drain();
    write_reg(2'd2, 12'hABC);
    write_reg(2'd3, 12'h123);
    send_pair(12'd2047, 12'd4000, 1'b0);
    send_pair(12'd100, 12'd1, 1'b1);
  endtask

  // hold the receiver so a result sits, the next record flows in and its
  // last pair stalls the input
  task automatic test_backpressure;
    int r, i;
    logic [SAMPLE_BITS-1:0] a, b;
    set_pedestals(12'd100, 12'd3000);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (8000) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    for (r = 0; r < 3; r++)
      for (i = 0; i < 6; i++) begin
        random_pair(a, b);
        send_pair(a, b, i == 5);
      end
  endtask

  task automatic test_random(input int items);
    int sent, len, i, phase;
    logic [SAMPLE_BITS-1:0] a, b;
    sent = 0;
    phase = 0;
    while (sent < items) begin
      if (sent / 100 != phase) begin
        phase = sent / 100;
        set_pedestals(PED_BITS'($urandom_range(0, 4095)),
                      PED_BITS'($urandom_range(0, 4095)));
        tx_idle_on = (phase != 2);
        rx_idle_on = (phase != 2);
      end
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                         : $urandom_range(1, 10);
      for (i = 0; i < len; i++) begin
        random_pair(a, b);
        send_pair(a, b, i == len - 1);
        sent++;
      end
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // receiver: random stalls after each transaction, plus the long hold-off
  always @(posedge clk) begin
    int draw;
    if (rst) begin
      out_ready <= 1'b0;
      rx_stall_left <= 0;
    end else if (rx_hold) begin
      out_ready <= 1'b0;
    end else if (out_ready && out_valid) begin
      draw = rx_idle_on ? $urandom_range(0, 12) : 0;
      rx_stall_left <= draw;
      out_ready <= (draw == 0);
    end else if (!out_ready) begin
      if (rx_stall_left <= 1) out_ready <= 1'b1;
      else rx_stall_left <= rx_stall_left - 1;
    end
  end

  // result checker: compare each output transaction with the oldest prediction
  always @(posedge clk) begin
    coef_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_coefs.size() == 0) begin
        $error("unexpected result: coefficient=%0d coefficient_valid=%0b",
               coefficient, coefficient_valid);
        err_count++;
      end else begin
        want = pending_coefs.pop_front();
        if (coefficient !== want.coef) begin
          $error("coefficient: expected %0d, actual %0d", want.coef, coefficient);
          err_count++;
        end
        if (coefficient_valid !== want.ok) begin
          $error("coefficient_valid: expected %0b, actual %0b",
                 want.ok, coefficient_valid);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(480);
    drain();
    if (err_count == 0 && pending_coefs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
